FILE: hw/rtl/rgb565_png_stored_encoder_defines.svh
// ----------------------------------------------------------------------------
// rgb565_png_stored_encoder_defines
// Assertion macros for the PNG stored encoder; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef RGB565_PNG_STORED_ENCODER_DEFINES_SVH
`define RGB565_PNG_STORED_ENCODER_DEFINES_SVH
`ifndef SYNTHESIS
`define RSPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RSPE_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define RSPE_ASSERT(lbl, prop, msg)
`define RSPE_NEVER(lbl, expr, msg)
`endif
`endif

FILE: hw/rtl/rspe_pkg.sv
// ----------------------------------------------------------------------------
// rspe_pkg
// Shared types, constants and CRC helper for the PNG stored encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package rspe_pkg;

  localparam int CFG_W        = 11;
  localparam int DEF_MAX_W    = 1024;
  localparam int DEF_MAX_H    = 1024;
  localparam int DEF_BLOCK    = 65535;
  localparam int RESET_WIDTH  = 320;
  localparam int RESET_HEIGHT = 240;
  localparam int QDEPTH       = 4;
  localparam int ADLER_MOD    = 65521;

  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;
  localparam logic [31:0] TYPE_IHDR = 32'h49484452;
  localparam logic [31:0] TYPE_IDAT = 32'h49444154;
  localparam logic [31:0] TYPE_IEND = 32'h49454E44;
  localparam logic [63:0] PNG_MAGIC = 64'h89504E470D0A1A0A;
  localparam logic [7:0]  ZLIB_CMF  = 8'h78;
  localparam logic [7:0]  ZLIB_FLG  = 8'h01;

  // header, block header and tail byte positions
  localparam logic [5:0] HDR_IHDR_TYPE = 6'd12;
  localparam logic [5:0] HDR_IDAT_LEN  = 6'd33;
  localparam logic [5:0] HDR_IDAT_TYPE = 6'd37;
  localparam logic [5:0] HDR_LAST      = 6'd42;
  localparam logic [5:0] TAIL_IEND     = 6'd12;
  localparam logic [5:0] TAIL_LAST     = 6'd19;
  localparam logic [5:0] BHDR_LAST     = 6'd4;

  typedef enum logic {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_START,
    PH_HEAD,
    PH_RAW,
    PH_BHDR,
    PH_TAIL
  } phase_t;

  typedef struct packed {
    logic [23:0] rgb;
    logic        first;
    logic        newrow;
    logic        last;
  } pix_entry_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] v);
    logic [31:0] c;
    c = c_in ^ {24'd0, v};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

  // big-endian byte of a word, sel 0 is the top byte
  function automatic logic [7:0] be_byte(input logic [31:0] w, input logic [1:0] sel);
    logic [7:0] b;
    case (sel)
      2'd0:    b = w[31:24];
      2'd1:    b = w[23:16];
      2'd2:    b = w[15:8];
      default: b = w[7:0];
    endcase
    return b;
  endfunction

endpackage

FILE: hw/rtl/rspe_front.sv
// ----------------------------------------------------------------------------
// rspe_front
// Config registers, frame position, pixel expansion and IDAT length unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rspe_front #(
  parameter int MAX_WIDTH  = rspe_pkg::DEF_MAX_W,
  parameter int MAX_HEIGHT = rspe_pkg::DEF_MAX_H,
  parameter int BLOCK_MAX  = rspe_pkg::DEF_BLOCK,
  parameter int RAW_W      = 22
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [rspe_pkg::CFG_W-1:0] cfg_data,
  input  logic                     pix_valid,
  input  logic [15:0]              pix,
  output logic                     pix_ready,
  output logic                     push,
  output rspe_pkg::pix_entry_t     entry,
  input  logic                     q_full,
  output logic [rspe_pkg::CFG_W-1:0] w_eff,
  output logic [rspe_pkg::CFG_W-1:0] h_eff,
  output logic [RAW_W-1:0]         raw_total,
  output logic [31:0]              idat_len,
  output logic                     len_ok
);
  import rspe_pkg::*;

  localparam int DV_W  = RAW_W + 1;
  localparam int SH    = DV_W + $clog2(BLOCK_MAX);
  localparam int RCP_W = DV_W + 1;
  // ceil(2^SH / BLOCK_MAX): exact quotient for every dividend below 2^DV_W
  localparam longint unsigned RCP =
    ((64'd1 << SH) + 64'(BLOCK_MAX) - 64'd1) / 64'(BLOCK_MAX);

  logic [CFG_W-1:0]        cfg_w, cfg_h, column, row;
  logic [4:0]              r5, b5;
  logic [5:0]              g6;
  logic                    col_end, row_end;
  logic [12:0]             row_bytes;
  logic [23:0]             prod;
  logic                    mul_pend, div_pend, len_pend;
  logic [DV_W-1:0]         dvd, blocks;
  logic [DV_W+RCP_W-1:0]   qprod;

  always_comb begin
    if (cfg_w < CFG_W'(2))                    w_eff = CFG_W'(2);
    else if (32'(cfg_w) > 32'(MAX_WIDTH))     w_eff = CFG_W'(MAX_WIDTH);
    else                                      w_eff = cfg_w;
    if (cfg_h < CFG_W'(1))                    h_eff = CFG_W'(1);
    else if (32'(cfg_h) > 32'(MAX_HEIGHT))    h_eff = CFG_W'(MAX_HEIGHT);
    else                                      h_eff = cfg_h;
  end

  assign pix_ready = !q_full;
  assign push      = pix_valid && pix_ready;
  assign r5        = pix[15:11];
  assign g6        = pix[10:5];
  assign b5        = pix[4:0];
  assign col_end   = (12'(column) + 12'd1) >= 12'(w_eff);
  assign row_end   = (12'(row) + 12'd1) >= 12'(h_eff);

  always_comb begin
    entry.rgb    = {b5, b5[4:2], g6, g6[5:4], r5, r5[4:2]};
    entry.first  = (column == '0) && (row == '0);
    entry.newrow = (column == '0);
    entry.last   = col_end && row_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_w  <= CFG_W'(RESET_WIDTH);
      cfg_h  <= CFG_W'(RESET_HEIGHT);
      column <= '0;
      row    <= '0;
    end else if (cfg_we) begin
      // any write aborts the frame
      if (cfg_index == CFG_WIDTH) cfg_w <= cfg_data;
      else                        cfg_h <= cfg_data;
      column <= '0;
      row    <= '0;
    end else if (push) begin
      if (col_end) begin
        column <= '0;
        row    <= row_end ? '0 : row + CFG_W'(1);
      end else begin
        column <= column + CFG_W'(1);
      end
    end
  end

  // IDAT length: h*(1+3w), ceil-divide by the block size through a reciprocal
  // multiply, then add block headers and zlib framing: three register stages
  assign row_bytes = {1'b0, w_eff, 1'b0} + 13'(w_eff) + 13'd1;
  assign prod      = h_eff * row_bytes;
  assign qprod     = dvd * RCP_W'(RCP);

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      mul_pend <= 1'b1;
      div_pend <= 1'b0;
      len_pend <= 1'b0;
      len_ok   <= 1'b0;
    end else if (mul_pend) begin
      mul_pend <= 1'b0;
      div_pend <= 1'b1;
    end else if (div_pend) begin
      div_pend <= 1'b0;
      len_pend <= 1'b1;
    end else if (len_pend) begin
      len_pend <= 1'b0;
      len_ok   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_pend) begin
      raw_total <= RAW_W'(prod);
      dvd       <= DV_W'(RAW_W'(prod)) + DV_W'(BLOCK_MAX - 1);
    end
    if (div_pend) begin
      blocks <= DV_W'(qprod >> SH);
    end
    if (len_pend) begin
      idat_len <= (32'(blocks) << 2) + 32'(blocks) + 32'(raw_total) + 32'd6;
    end
  end

endmodule

FILE: hw/rtl/rspe_fifo.sv
// ----------------------------------------------------------------------------
// rspe_fifo
// Short queue of classified pixels between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rspe_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  rspe_pkg::pix_entry_t wdata,
  output logic                 full,
  input  logic                 pop,
  output logic                 rvalid,
  output rspe_pkg::pix_entry_t rdata
);
  import rspe_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  pix_entry_t       mem [QDEPTH];
  logic [PW-1:0]    wp, rp;
  logic [PW:0]      count;

  assign full   = (count == (PW+1)'(QDEPTH));
  assign rvalid = (count != '0);
  assign rdata  = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + PW'(1);
      if (pop)  rp <= rp + PW'(1);
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

FILE: hw/rtl/rspe_back.sv
// ----------------------------------------------------------------------------
// rspe_back
// Byte sequencer: headers, stored blocks, checksums and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rspe_back #(
  parameter int BLOCK_MAX = 65535,
  parameter int RAW_W     = 22
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  rspe_pkg::pix_entry_t       q,
  output logic                       pop,
  input  logic [rspe_pkg::CFG_W-1:0] w_eff,
  input  logic [rspe_pkg::CFG_W-1:0] h_eff,
  input  logic [RAW_W-1:0]           raw_total,
  input  logic [31:0]                idat_len,
  input  logic                       len_ok,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [7:0]                 m_tdata,
  output logic                       m_tlast,
  output logic [0:0]                 m_tuser
);
  import rspe_pkg::*;

  phase_t           phase, phase_next, cur_ph;
  logic [5:0]       idx, idx_next;
  logic [1:0]       ri, ri_next, cur_ri, start_ri;
  logic [15:0]      blk, blk_next, take, take_next, take_val;
  logic [RAW_W-1:0] raw_left, raw_left_next;
  logic             fin, fin_next, bh_done, bh_done_next;
  logic [31:0]      crc, crc_next, crc_src;
  logic [15:0]      adl, adl_next, adh, adh_next, low_mod;
  logic [16:0]      low_sum, high_sum;
  logic             room, emit, rlast, flast, crc_upd, crc_init, adl_upd;
  logic [7:0]       obyte;

  assign room     = !m_tvalid || m_tready;
  assign start_ri = q.newrow ? 2'd0 : 2'd1;
  assign take_val = (32'(raw_left) < 32'(BLOCK_MAX)) ? 16'(raw_left) : 16'(BLOCK_MAX);

  always_comb begin
    phase_next    = phase;
    idx_next      = idx;
    ri_next       = ri;
    blk_next      = blk;
    raw_left_next = raw_left;
    take_next     = take;
    fin_next      = fin;
    bh_done_next  = bh_done;
    emit          = 1'b0;
    obyte         = 8'h00;
    rlast         = 1'b0;
    flast         = 1'b0;
    pop           = 1'b0;
    crc_upd       = 1'b0;
    crc_init      = 1'b0;
    adl_upd       = 1'b0;
    cur_ph        = phase;
    cur_ri        = ri;
    if (phase == PH_START) begin
      cur_ph = q.first ? PH_HEAD : PH_RAW;
      cur_ri = start_ri;
    end
    if (phase == PH_START && q_valid && q.first) begin
      blk_next      = '0;
      raw_left_next = raw_total;
      bh_done_next  = 1'b0;
    end
    if (q_valid && room) begin
      case (cur_ph)
        PH_HEAD: begin
          // hold at the length field until the length unit is done
          if (!(idx == HDR_IDAT_LEN && !len_ok)) begin
            emit     = 1'b1;
            crc_init = (idx == HDR_IHDR_TYPE) || (idx == HDR_IDAT_TYPE);
            case (idx) inside
              [6'd0:6'd7]:   obyte = be_byte(idx[2] ? PNG_MAGIC[31:0] : PNG_MAGIC[63:32],
                                             idx[1:0]);
              [6'd8:6'd10]:  obyte = 8'h00;
              6'd11:         obyte = 8'd13;
              [6'd12:6'd15]: begin obyte = be_byte(TYPE_IHDR, idx[1:0]); crc_upd = 1'b1; end
              [6'd16:6'd19]: begin obyte = be_byte(32'(w_eff), idx[1:0]); crc_upd = 1'b1; end
              [6'd20:6'd23]: begin obyte = be_byte(32'(h_eff), idx[1:0]); crc_upd = 1'b1; end
              6'd24:         begin obyte = 8'd8; crc_upd = 1'b1; end
              6'd25:         begin obyte = 8'd2; crc_upd = 1'b1; end
              [6'd26:6'd28]: begin obyte = 8'd0; crc_upd = 1'b1; end
              [6'd29:6'd32]: obyte = be_byte(~crc, 2'(idx - 6'd29));
              [6'd33:6'd36]: obyte = be_byte(idat_len, 2'(idx - 6'd33));
              [6'd37:6'd40]: begin
                obyte   = be_byte(TYPE_IDAT, 2'(idx - 6'd37));
                crc_upd = 1'b1;
              end
              6'd41:         begin obyte = ZLIB_CMF; crc_upd = 1'b1; end
              default:       begin obyte = ZLIB_FLG; crc_upd = 1'b1; end
            endcase
            if (idx == HDR_LAST) begin
              phase_next = PH_RAW;
              idx_next   = '0;
              ri_next    = start_ri;
            end else begin
              phase_next = PH_HEAD;
              idx_next   = idx + 6'd1;
            end
          end
        end
        PH_RAW: begin
          if (blk == '0 && !bh_done) begin
            // open a stored block first
            take_next  = take_val;
            fin_next   = (32'(take_val) == 32'(raw_left));
            phase_next = PH_BHDR;
            idx_next   = '0;
            ri_next    = cur_ri;
          end else begin
            emit    = 1'b1;
            crc_upd = 1'b1;
            adl_upd = 1'b1;
            case (cur_ri)
              2'd0:    obyte = 8'h00;
              2'd1:    obyte = q.rgb[7:0];
              2'd2:    obyte = q.rgb[15:8];
              default: obyte = q.rgb[23:16];
            endcase
            blk_next     = (blk != '0) ? blk - 16'd1 : blk;
            bh_done_next = 1'b0;
            if (cur_ri == 2'd3) begin
              idx_next = '0;
              if (q.last) begin
                phase_next = PH_TAIL;
              end else begin
                rlast      = 1'b1;
                pop        = 1'b1;
                phase_next = PH_START;
              end
            end else begin
              ri_next    = cur_ri + 2'd1;
              phase_next = PH_RAW;
            end
          end
        end
        PH_BHDR: begin
          emit    = 1'b1;
          crc_upd = 1'b1;
          case (idx)
            6'd0:    obyte = {7'd0, fin};
            6'd1:    obyte = take[7:0];
            6'd2:    obyte = take[15:8];
            6'd3:    obyte = ~take[7:0];
            default: obyte = ~take[15:8];
          endcase
          if (idx == BHDR_LAST) begin
            blk_next      = take;
            raw_left_next = raw_left - RAW_W'(take);
            bh_done_next  = 1'b1;
            phase_next    = PH_RAW;
          end else begin
            idx_next = idx + 6'd1;
          end
        end
        PH_TAIL: begin
          emit     = 1'b1;
          crc_init = (idx == TAIL_IEND);
          case (idx) inside
            [6'd0:6'd3]:   begin obyte = be_byte({adh, adl}, idx[1:0]); crc_upd = 1'b1; end
            [6'd4:6'd7]:   obyte = be_byte(~crc, idx[1:0]);
            [6'd8:6'd11]:  obyte = 8'h00;
            [6'd12:6'd15]: begin obyte = be_byte(TYPE_IEND, idx[1:0]); crc_upd = 1'b1; end
            default:       obyte = be_byte(~crc, idx[1:0]);
          endcase
          if (idx == TAIL_LAST) begin
            rlast      = 1'b1;
            flast      = 1'b1;
            pop        = 1'b1;
            phase_next = PH_START;
            idx_next   = '0;
          end else begin
            idx_next = idx + 6'd1;
          end
        end
        default: phase_next = PH_START;
      endcase
    end
  end

  // running checksums
  always_comb begin
    crc_src  = crc_init ? CRC_INIT : crc;
    crc_next = crc_upd ? crc_byte(crc_src, obyte) : crc;
    low_sum  = 17'(adl) + 17'(obyte);
    low_mod  = (low_sum >= 17'(ADLER_MOD)) ? 16'(low_sum - 17'(ADLER_MOD)) : low_sum[15:0];
    high_sum = 17'(adh) + 17'(low_mod);
    adl_next = adl;
    adh_next = adh;
    if (phase == PH_START && q_valid && q.first) begin
      adl_next = 16'd1;
      adh_next = 16'd0;
    end else if (adl_upd) begin
      adl_next = low_mod;
      adh_next = (high_sum >= 17'(ADLER_MOD)) ? 16'(high_sum - 17'(ADLER_MOD))
                                               : high_sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_START;
      idx      <= '0;
      ri       <= '0;
      blk      <= '0;
      raw_left <= '0;
      bh_done  <= 1'b0;
      crc      <= CRC_INIT;
      adl      <= 16'd1;
      adh      <= 16'd0;
      m_tvalid <= 1'b0;
    end else begin
      phase    <= phase_next;
      idx      <= idx_next;
      ri       <= ri_next;
      blk      <= blk_next;
      raw_left <= raw_left_next;
      bh_done  <= bh_done_next;
      crc      <= crc_next;
      adl      <= adl_next;
      adh      <= adh_next;
      if (emit)          m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    take <= take_next;
    fin  <= fin_next;
    if (emit) begin
      m_tdata <= obyte;
      m_tlast <= rlast;
      m_tuser <= flast;
    end
  end

endmodule

FILE: hw/rtl/rgb565_png_stored_encoder.sv
// ----------------------------------------------------------------------------
// rgb565_png_stored_encoder
// RGB565 pixel stream in, uncompressed PNG byte stream out.
// ----------------------------------------------------------------------------
// channel  | dir | payload
// s_*      | in  | tdata[15:0] pixel
// m_*      | out | tdata[7:0] out_byte, tlast run_last, tuser[0] file_last
// cfg_*    | in  | index 0 image_width, 1 image_height, data 11 bits
//
// One output byte per cycle from the back sequencer while a pixel is queued and the
// output is not stalled: a pixel gives 3 bytes, 4 at a row start, 43 more for the file
// head and 20 more for the last pixel, plus 5 header bytes per stored block, which is
// opened in a step that emits no byte. The byte output register sets the rate.
// Reset and any config write restart the IDAT length unit; the
// head holds at the length field until it is done.
// The front keeps taking pixels into a 4-entry queue while the output stalls, until it is full.
`timescale 1ns / 1ps
module rgb565_png_stored_encoder #(
  parameter int MAX_WIDTH  = rspe_pkg::DEF_MAX_W,
  parameter int MAX_HEIGHT = rspe_pkg::DEF_MAX_H,
  parameter int BLOCK_MAX  = rspe_pkg::DEF_BLOCK
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [15:0]                s_tdata,   // [15:0] pixel
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [7:0]                 m_tdata,   // [7:0] out_byte
  output logic                       m_tlast,
  output logic [0:0]                 m_tuser,   // [0] file_last
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [rspe_pkg::CFG_W-1:0] cfg_data
);
  import rspe_pkg::*;
  `include "rgb565_png_stored_encoder_defines.svh"

  localparam int RAW_W = $clog2(MAX_HEIGHT * (1 + 3 * MAX_WIDTH) + 1);

  logic             push, q_full, q_valid, pop, len_ok;
  pix_entry_t       entry, q_head;
  logic [CFG_W-1:0] w_eff, h_eff;
  logic [RAW_W-1:0] raw_total;
  logic [31:0]      idat_len;

  rspe_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .BLOCK_MAX (BLOCK_MAX),
    .RAW_W     (RAW_W)
  ) u_front (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .pix_valid(s_tvalid), .pix(s_tdata), .pix_ready(s_tready),
    .push, .entry, .q_full,
    .w_eff, .h_eff, .raw_total, .idat_len, .len_ok
  );

  rspe_fifo u_fifo (
    .clk, .rst, .push, .wdata(entry), .full(q_full),
    .pop, .rvalid(q_valid), .rdata(q_head)
  );

  rspe_back #(
    .BLOCK_MAX(BLOCK_MAX),
    .RAW_W    (RAW_W)
  ) u_back (
    .clk, .rst, .q_valid, .q(q_head), .pop,
    .w_eff, .h_eff, .raw_total, .idat_len, .len_ok,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast, .m_tuser
  );

  `RSPE_ASSERT(a_file_last_ends_run, m_tvalid && m_tuser[0] |-> m_tlast, "file_last without tlast")
  `RSPE_ASSERT(a_len_drop_on_cfg, $fell(len_ok) |-> $past(cfg_we), "IDAT length lost without config write")
  `RSPE_NEVER(a_pop_empty, pop && !q_valid, "queue popped while empty")

endmodule
